>>> rtl/dq_pkg.sv
// dq_pkg: command and status codes and transaction types for the deque
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

  // command codes
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_PEEK_FRONT = 3'd4;
  localparam logic [2:0] CMD_PEEK_BACK  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int unsigned OCC_W = 5;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] push_value;
  } dq_req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [OCC_W-1:0]   occupancy;
    logic               is_empty;
  } dq_rsp_t;

  // result info held by the controller until the memory read returns
  typedef struct packed {
    logic             done;
    logic             use_rdata;
    logic [1:0]       status;
    logic [OCC_W-1:0] occupancy;
    logic             is_empty;
  } dq_meta_t;

endpackage

`default_nettype wire

>>> rtl/dq_ram.sv
// dq_ram: slot storage, one write port and one read port, registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module dq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire logic signed [31:0]   wdata_i,
  input  wire logic                 re_i,
  input  wire logic [AW-1:0]        raddr_i,
  output logic signed [31:0]        rdata_o
);

  logic signed [31:0] mem_q [DEPTH];
  logic signed [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/dq_ctrl.sv
// dq_ctrl: head index and entry count, slot addressing and result status
// depends on dq_pkg
`timescale 1ns / 1ps
`default_nettype none

module dq_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned CW    = 5
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [2:0]      cmd_i,
  output logic                 we_o,
  output logic [AW-1:0]        waddr_o,
  output logic                 re_o,
  output logic [AW-1:0]        raddr_o,
  output dq_pkg::dq_meta_t     meta_o
);
  import dq_pkg::*;

  localparam int unsigned SW = CW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  dq_meta_t      meta_q, meta_d;

  logic          full, empty;
  logic [SW-1:0] tail_sum, last_sum;
  logic [AW-1:0] tail_idx, last_idx, head_dec, head_inc;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  // slot past the back and the back slot itself, wrapped with one subtract
  assign tail_sum = SW'(head_q) + SW'(count_q);
  assign last_sum = tail_sum - SW'(1);
  assign tail_idx = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
  assign last_idx = (last_sum >= DEPTH_S) ? AW'(last_sum - DEPTH_S) : AW'(last_sum);
  assign head_dec = (head_q == '0) ? LAST_IDX : head_q - AW'(1);
  assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    we_o    = 1'b0;
    waddr_o = tail_idx;
    re_o    = 1'b0;
    raddr_o = head_q;
    meta_d  = '0;
    if (accept_i) begin
      meta_d.done   = 1'b1;
      meta_d.status = ST_OK;
      case (cmd_i)
        CMD_PUSH_FRONT: begin
          if (full) begin
            meta_d.status = ST_FULL;
          end else begin
            we_o    = 1'b1;
            waddr_o = head_dec;
            head_d  = head_dec;
            count_d = count_q + CW'(1);
          end
        end
        CMD_PUSH_BACK: begin
          if (full) begin
            meta_d.status = ST_FULL;
          end else begin
            we_o    = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
        CMD_POP_FRONT, CMD_PEEK_FRONT: begin
          if (empty) begin
            meta_d.status = ST_EMPTY;
          end else begin
            re_o             = 1'b1;
            meta_d.use_rdata = 1'b1;
            if (cmd_i == CMD_POP_FRONT) begin
              head_d  = head_inc;
              count_d = count_q - CW'(1);
            end
          end
        end
        CMD_POP_BACK, CMD_PEEK_BACK: begin
          if (empty) begin
            meta_d.status = ST_EMPTY;
          end else begin
            re_o             = 1'b1;
            raddr_o          = last_idx;
            meta_d.use_rdata = 1'b1;
            if (cmd_i == CMD_POP_BACK) begin
              count_d = count_q - CW'(1);
            end
          end
        end
        default: begin
          meta_d.status = ST_OK;
        end
      endcase
      meta_d.occupancy = OCC_W'(count_d);
      meta_d.is_empty  = (count_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      meta_q  <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      meta_q  <= meta_d;
    end
  end

  assign meta_o = meta_q;

endmodule

`default_nettype wire

>>> rtl/double_ended_queue.sv
// double_ended_queue: ring-buffer deque of signed 32-bit values, top level
// depends on dq_pkg, dq_ctrl and dq_ram
// result timing: each transaction's result appears in the cycle after start is taken
// throughput: one transaction per cycle, set by the single slot memory access
//   (one write or one read) each command makes; busy_o stays low
// reset: head index and entry count clear to zero, slot contents are not cleared
// results carry a one-cycle strobe on done_o; the receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire dq_pkg::dq_req_t  req_i,
  output logic                  done_o,
  output dq_pkg::dq_rsp_t       rsp_o
);
  import dq_pkg::*;

  // slot index width and entry count width (count must hold DEPTH itself)
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic               accept;
  logic               we, re;
  logic [AW-1:0]      waddr, raddr;
  logic signed [31:0] rdata;
  dq_meta_t           meta;

  // every command is one memory access, so a new transaction fits each cycle
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // pointer bookkeeping happens at accept, the slot read returns in the next cycle
  dq_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .cmd_i   (req_i.cmd),
    .we_o    (we),
    .waddr_o (waddr),
    .re_o    (re),
    .raddr_o (raddr),
    .meta_o  (meta)
  );

  // a push writes its slot at the accept edge, so a read issued on the
  // next transaction already sees it; one command never reads and writes
  dq_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(req_i.push_value),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // read value is zero for pushes, errors and unused command codes
  always_comb begin
    rsp_o.read_value = meta.use_rdata ? rdata : '0;
    rsp_o.status     = meta.status;
    rsp_o.occupancy  = meta.occupancy;
    rsp_o.is_empty   = meta.is_empty;
  end
  assign done_o = meta.done;

  // a result only follows an accepted transaction
  a_done_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o))
    else $error("result strobe without an accepted transaction");

  // an accepted transaction always yields a result next cycle
  a_accept_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("accepted transaction produced no result");

  // an empty error leaves the deque empty and reads zero
  a_empty_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_EMPTY) |-> (rsp_o.is_empty && rsp_o.read_value == '0))
    else $error("empty error with stored entries or nonzero value");

  // a full error means entries are stored and nothing was read
  a_full_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_FULL) |-> (!rsp_o.is_empty && rsp_o.read_value == '0))
    else $error("full error on an empty deque or with a read value");

endmodule

`default_nettype wire

>>> bench/double_ended_queue_tb.sv
// double_ended_queue_tb: self-checking bench for the ring-buffer deque
// drives random and directed push/pop/peek transactions, predicts every result
// depends on dq_pkg and double_ended_queue
`timescale 1ns / 1ps

module double_ended_queue_tb;
  import dq_pkg::*;

  localparam int unsigned RING_DEPTH = 16;
  // cycles with no accepted transaction before the run is declared hung
  localparam int unsigned STALL_LIMIT = 1000;
  // random stimulus is issued in segments, each with its own command mix
  localparam int unsigned SEGMENT_LEN = 50;
  localparam int unsigned NUM_SEGMENTS = 30;

  // unused command codes, expected to act as no-ops
  localparam logic [2:0] CMD_RSVD_LO = 3'd6;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;

  // command mixes for the random segments
  typedef enum int unsigned {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN,
    MIX_LOOK
  } cmd_mix_e;

  logic    clk_i;
  logic    rst_ni = 1'b0;
  logic    start_i = 1'b0;
  logic    busy_o;
  dq_req_t req_i = '0;
  logic    done_o;
  dq_rsp_t rsp_o;

  // no idle gaps between requests while set
  bit back_to_back = 1'b0;

  // expected-result tracker with its own copy of the deque contents
  class deque_scoreboard;
    logic [31:0]  ring[RING_DEPTH];
    int unsigned  head;
    int unsigned  count;
    dq_rsp_t      expected_q[$];
    int unsigned  errors;

    function new();
      head = 0;
      count = 0;
      errors = 0;
      foreach (ring[i]) ring[i] = '0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // apply one accepted request to the shadow deque and queue its result
    function void note_request(dq_req_t req);
      dq_rsp_t     rsp;
      int unsigned slot;
      rsp = '0;
      rsp.status = ST_OK;
      case (req.cmd)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (count >= RING_DEPTH) begin
            rsp.status = ST_FULL;
          end else if (req.cmd == CMD_PUSH_FRONT) begin
            head = (head + RING_DEPTH - 1) % RING_DEPTH;
            ring[head] = req.push_value;
            count++;
          end else begin
            ring[(head + count) % RING_DEPTH] = req.push_value;
            count++;
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
          if (count == 0) begin
            rsp.status = ST_EMPTY;
          end else begin
            if (req.cmd == CMD_POP_FRONT || req.cmd == CMD_PEEK_FRONT)
              slot = head;
            else
              slot = (head + count - 1) % RING_DEPTH;
            rsp.read_value = ring[slot];
            if (req.cmd == CMD_POP_FRONT) begin
              head = (head + 1) % RING_DEPTH;
              count--;
            end else if (req.cmd == CMD_POP_BACK) begin
              count--;
            end
          end
        end
        default: begin
        end
      endcase
      rsp.occupancy = count[OCC_W-1:0];
      rsp.is_empty = (count == 0);
      expected_q.push_back(rsp);
    endfunction

    task check_response(dq_rsp_t rsp);
      dq_rsp_t exp_rsp;
      if (expected_q.size() == 0) begin
        report("result with no transaction outstanding");
        return;
      end
      exp_rsp = expected_q.pop_front();
      if (rsp.read_value !== exp_rsp.read_value)
        report($sformatf("read_value got %0d expected %0d",
                         rsp.read_value, exp_rsp.read_value));
      if (rsp.status !== exp_rsp.status)
        report($sformatf("status got %0d expected %0d", rsp.status, exp_rsp.status));
      if (rsp.occupancy !== exp_rsp.occupancy)
        report($sformatf("occupancy got %0d expected %0d",
                         rsp.occupancy, exp_rsp.occupancy));
      if (rsp.is_empty !== exp_rsp.is_empty)
        report($sformatf("is_empty got %0b expected %0b",
                         rsp.is_empty, exp_rsp.is_empty));
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  deque_scoreboard deque_sb = new();

  double_ended_queue #(
    .DEPTH (RING_DEPTH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // 50 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // monitor: sample handshakes on the edge that accepts them
  // the request is noted before the result is checked, so ordering holds
  // even if a result ever came in the same cycle as its transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) deque_sb.note_request(req_i);
      if (done_o) deque_sb.check_response(rsp_o);
    end
  end

  // watchdog: any accepted request or result restarts the count
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[%0t] timeout: no transaction for %0d cycles", $realtime, idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // issue one request; returns on the edge at which it is taken
  task automatic send_command(input logic [2:0] op, input logic [31:0] value);
    int unsigned gap;
    gap = back_to_back ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= '{cmd: op, push_value: value};
    // busy_o read here is its value just before the edge
    do @(posedge clk_i); while (busy_o);
  endtask

  // push value: mostly uniform, sometimes a corner value
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // command for one random transaction, weighted by the segment's mix
  function automatic logic [2:0] pick_command(cmd_mix_e mix);
    int unsigned roll;
    int unsigned push_pct;
    int unsigned pop_pct;
    bit          front_end;
    roll = $urandom_range(0, 99);
    front_end = $urandom_range(0, 1);
    case (mix)
      MIX_FILL:  begin push_pct = 70; pop_pct = 20; end
      MIX_DRAIN: begin push_pct = 20; pop_pct = 70; end
      MIX_EVEN:  begin push_pct = 45; pop_pct = 40; end
      default:   begin push_pct = 35; pop_pct = 20; end
    endcase
    // a few unused codes as noise
    if (roll < 3) return $urandom_range(0, 1) ? CMD_RSVD_LO : CMD_RSVD_HI;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) return front_end ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    if (roll < push_pct + pop_pct) return front_end ? CMD_POP_FRONT : CMD_POP_BACK;
    return front_end ? CMD_PEEK_FRONT : CMD_PEEK_BACK;
  endfunction

  initial begin
    cmd_mix_e mix;

    // reset held low first, then released
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    // pops and peeks on an empty deque
    send_command(CMD_POP_FRONT, pick_value());
    send_command(CMD_POP_BACK, pick_value());
    send_command(CMD_PEEK_FRONT, pick_value());
    send_command(CMD_PEEK_BACK, pick_value());
    // unused codes are no-ops
    send_command(CMD_RSVD_LO, pick_value());
    send_command(CMD_RSVD_HI, pick_value());
    // extremes at both ends, then read them back
    send_command(CMD_PUSH_FRONT, 32'h7fff_ffff);
    send_command(CMD_PUSH_BACK, 32'h8000_0000);
    send_command(CMD_PEEK_FRONT, '0);
    send_command(CMD_PEEK_BACK, '0);
    send_command(CMD_POP_BACK, '0);
    send_command(CMD_POP_FRONT, '0);
    // fill to capacity from both ends, then push into a full ring
    for (int i = 0; i < RING_DEPTH; i++)
      send_command(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_value());
    send_command(CMD_PUSH_FRONT, pick_value());
    send_command(CMD_PUSH_BACK, pick_value());

    // --- random part ---
    // each segment gets its own mix so the ring swings between full and empty
    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      mix = cmd_mix_e'($urandom_range(0, 3));
      back_to_back = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < SEGMENT_LEN; n++)
        send_command(pick_command(mix), pick_value());
    end

    // drain: drop start, let outstanding results land
    start_i <= 1'b0;
    while (deque_sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (deque_sb.pending() != 0)
      deque_sb.report($sformatf("%0d results never arrived", deque_sb.pending()));

    if (deque_sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
